// File: hdl/cartesian_admittance_filter_top_defines.svh
// Assertion macros shared by the admittance filter RTL.
`ifndef CARTESIAN_ADMITTANCE_FILTER_TOP_DEFINES_SVH
`define CARTESIAN_ADMITTANCE_FILTER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Implication in the same cycle.
`define CAF_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication in the next cycle.
`define CAF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CAF_ASSERT_NOW(label, clk, rst, ante, cons)
`define CAF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: hdl/caf_pkg.sv
package caf_pkg;

  // transaction payloads
  typedef struct packed {
    logic [2:0]         axis;
    logic signed [31:0] force_req;
  } cmd_t;

  typedef struct packed {
    logic [2:0]         axis_out;
    logic signed [31:0] position;
    logic signed [31:0] velocity;
  } res_t;

  // register map, index = paddr[4:2]
  localparam logic [2:0] REG_DAMPING_A    = 3'd0;
  localparam logic [2:0] REG_DAMPING_B    = 3'd1;
  localparam logic [2:0] REG_STIFFNESS_A  = 3'd2;
  localparam logic [2:0] REG_STIFFNESS_B  = 3'd3;
  localparam logic [2:0] REG_INV_MASS     = 3'd4;
  localparam logic [2:0] REG_TIME_STEP    = 3'd5;
  localparam logic [2:0] REG_POS_FORCE    = 3'd6;
  localparam logic [2:0] REG_GROUP_B      = 3'd7;

  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_IDLE = 4'd0;
  localparam logic [STEP_W-1:0] STEP_LAST = 4'd11;

  // datapath operations
  localparam logic [2:0] OP_LOAD  = 3'd0; // fetch state, signed force into acc
  localparam logic [2:0] OP_MUL   = 3'd1; // prod = a * b
  localparam logic [2:0] OP_SUB16 = 3'd2; // acc -= round(prod / 2^16)
  localparam logic [2:0] OP_SAT   = 3'd3; // x = sat(acc)
  localparam logic [2:0] OP_RND16 = 3'd4; // x = sat(round(prod / 2^16))
  localparam logic [2:0] OP_ADDV  = 3'd5; // x = sat(v + round(prod / 2^32))
  localparam logic [2:0] OP_ADDP  = 3'd6; // p = sat(p + round(prod / 2^32)), write back

  // multiplier operand selects
  localparam logic [1:0] A_V = 2'd0;
  localparam logic [1:0] A_P = 2'd1;
  localparam logic [1:0] A_X = 2'd2;

  localparam logic [1:0] B_DAMP  = 2'd0;
  localparam logic [1:0] B_STIFF = 2'd1;
  localparam logic [1:0] B_IMASS = 2'd2;
  localparam logic [1:0] B_DT    = 2'd3;

  // step conditions
  localparam logic [1:0] C_NONE = 2'd0; // always advance
  localparam logic [1:0] C_ITEM = 2'd1; // wait for an in-range transaction
  localparam logic [1:0] C_OUT  = 2'd2; // wait for a free result register

  typedef struct packed {
    logic [2:0] op;
    logic [1:0] asel;
    logic [1:0] bsel;
    logic [1:0] cond;
    logic       last;
  } uc_t;

  function automatic uc_t ucode(input logic [STEP_W-1:0] step);
    uc_t w;
    w = '{op: OP_MUL, asel: A_V, bsel: B_DAMP, cond: C_NONE, last: 1'b0};
    case (step)
      4'd0:  w = '{op: OP_LOAD,  asel: A_V, bsel: B_DAMP,  cond: C_ITEM, last: 1'b0};
      4'd1:  w = '{op: OP_MUL,   asel: A_V, bsel: B_DAMP,  cond: C_NONE, last: 1'b0};
      4'd2:  w = '{op: OP_SUB16, asel: A_V, bsel: B_DAMP,  cond: C_NONE, last: 1'b0};
      4'd3:  w = '{op: OP_MUL,   asel: A_P, bsel: B_STIFF, cond: C_NONE, last: 1'b0};
      4'd4:  w = '{op: OP_SUB16, asel: A_P, bsel: B_STIFF, cond: C_NONE, last: 1'b0};
      4'd5:  w = '{op: OP_SAT,   asel: A_X, bsel: B_IMASS, cond: C_NONE, last: 1'b0};
      4'd6:  w = '{op: OP_MUL,   asel: A_X, bsel: B_IMASS, cond: C_NONE, last: 1'b0};
      4'd7:  w = '{op: OP_RND16, asel: A_X, bsel: B_DT,    cond: C_NONE, last: 1'b0};
      4'd8:  w = '{op: OP_MUL,   asel: A_X, bsel: B_DT,    cond: C_NONE, last: 1'b0};
      4'd9:  w = '{op: OP_ADDV,  asel: A_X, bsel: B_DT,    cond: C_NONE, last: 1'b0};
      4'd10: w = '{op: OP_MUL,   asel: A_X, bsel: B_DT,    cond: C_NONE, last: 1'b0};
      4'd11: w = '{op: OP_ADDP,  asel: A_X, bsel: B_DT,    cond: C_OUT,  last: 1'b1};
      default: w = '{op: OP_LOAD, asel: A_V, bsel: B_DAMP, cond: C_NONE, last: 1'b1};
    endcase
    return w;
  endfunction

  // saturate to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    logic signed [31:0] r;
    if (x > 66'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  // round to nearest, ties up
  function automatic logic signed [65:0] rnd16(input logic signed [65:0] x);
    return (x + 66'sd32768) >>> 16;
  endfunction

  function automatic logic signed [65:0] rnd32(input logic signed [65:0] x);
    return (x + 66'sd2147483648) >>> 32;
  endfunction

endpackage

// File: hdl/cartesian_admittance_filter_top.sv
// A new command is taken only once the previous one has been through the
// 12-step microcode program that drives the single shared 33x33 multiplier;
// the last step also waits for a free result register.
// Commands with an axis beyond the axis count are taken and dropped without a result.
// Reset (rst, synchronous, active high) restores the register defaults and
// clears every axis position and velocity at once.
`include "cartesian_admittance_filter_top_defines.svh"

module cartesian_admittance_filter_top #(
  parameter int AXES = 6
) (
  input  logic               clk,
  input  logic               rst,
  // command channel
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  caf_pkg::cmd_t      cmd,
  // result channel
  output logic               res_valid,
  input  logic               res_stall,
  output caf_pkg::res_t      res,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int AXW = (AXES > 1) ? $clog2(AXES) : 1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [31:0] damping_a, damping_b, stiffness_a, stiffness_b;
  logic [31:0] inverse_mass, time_step;
  logic [5:0]  positive_force_mask, group_b_mask;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      damping_a           <= 32'd196608;
      damping_b           <= 32'd32768000;
      stiffness_a         <= 32'd0;
      stiffness_b         <= 32'd6553600;
      inverse_mass        <= 32'd65536;
      time_step           <= 32'd4294967;
      positive_force_mask <= 6'd40;
      group_b_mask        <= 6'd60;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        caf_pkg::REG_DAMPING_A:   damping_a           <= pwdata;
        caf_pkg::REG_DAMPING_B:   damping_b           <= pwdata;
        caf_pkg::REG_STIFFNESS_A: stiffness_a         <= pwdata;
        caf_pkg::REG_STIFFNESS_B: stiffness_b         <= pwdata;
        caf_pkg::REG_INV_MASS:    inverse_mass        <= pwdata;
        caf_pkg::REG_TIME_STEP:   time_step           <= pwdata;
        caf_pkg::REG_POS_FORCE:   positive_force_mask <= pwdata[5:0];
        caf_pkg::REG_GROUP_B:     group_b_mask        <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      caf_pkg::REG_DAMPING_A:   prdata = damping_a;
      caf_pkg::REG_DAMPING_B:   prdata = damping_b;
      caf_pkg::REG_STIFFNESS_A: prdata = stiffness_a;
      caf_pkg::REG_STIFFNESS_B: prdata = stiffness_b;
      caf_pkg::REG_INV_MASS:    prdata = inverse_mass;
      caf_pkg::REG_TIME_STEP:   prdata = time_step;
      caf_pkg::REG_POS_FORCE:   prdata = {26'd0, positive_force_mask};
      caf_pkg::REG_GROUP_B:     prdata = {26'd0, group_b_mask};
      default:                  prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: step counter over the control store in the package.
  // Step 0 waits for an in-range command transaction, the last step waits for a free
  // result register; everything between runs unconditionally.
  // ---------------------------------------------------------------------------
  logic [caf_pkg::STEP_W-1:0] step, step_next;
  caf_pkg::uc_t               uc;
  logic                       axis_ok;
  logic                       go;

  assign uc        = caf_pkg::ucode(step);
  assign axis_ok   = (5'(cmd.axis) < 5'(AXES));
  assign cmd_stall = (step != caf_pkg::STEP_IDLE);

  always_comb begin
    case (uc.cond)
      caf_pkg::C_ITEM: go = cmd_valid && axis_ok;
      caf_pkg::C_OUT:  go = !(res_valid && res_stall);
      default:         go = 1'b1;
    endcase
    if (!go) begin
      step_next = step;
    end else if (uc.last) begin
      step_next = caf_pkg::STEP_IDLE;
    end else begin
      step_next = step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= caf_pkg::STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath: one shared multiplier, 66-bit accumulator, working registers
  // ---------------------------------------------------------------------------
  logic signed [31:0] axis_position [AXES];
  logic signed [31:0] axis_velocity [AXES];

  logic [2:0]         ax_r;
  logic               sel_b;
  logic signed [31:0] p_r, v_r, x_r;
  logic signed [65:0] acc_r, prod_r;

  logic [AXW-1:0]     cmd_idx, ax_idx;
  logic [7:0]         pos_bits, grp_bits;
  logic signed [31:0] mul_a;
  logic [31:0]        mul_b;
  logic signed [65:0] prod;
  logic signed [31:0] new_pos;

  assign cmd_idx  = AXW'(cmd.axis);
  assign ax_idx   = AXW'(ax_r);
  // axes above bit 5 read as subtract, set A
  assign pos_bits = {2'b00, positive_force_mask};
  assign grp_bits = {2'b00, group_b_mask};

  always_comb begin
    case (uc.asel)
      caf_pkg::A_V: mul_a = v_r;
      caf_pkg::A_P: mul_a = p_r;
      default:      mul_a = x_r;
    endcase
    case (uc.bsel)
      caf_pkg::B_DAMP:  mul_b = sel_b ? damping_b : damping_a;
      caf_pkg::B_STIFF: mul_b = sel_b ? stiffness_b : stiffness_a;
      caf_pkg::B_IMASS: mul_b = inverse_mass;
      default:          mul_b = time_step;
    endcase
  end

  assign prod    = $signed({mul_a[31], mul_a}) * $signed({1'b0, mul_b});
  assign new_pos = caf_pkg::sat32(66'(p_r) + caf_pkg::rnd32(prod_r));

  always_ff @(posedge clk) begin
    if (go) begin
      case (uc.op)
        caf_pkg::OP_LOAD: begin
          ax_r  <= cmd.axis;
          sel_b <= grp_bits[cmd.axis];
          p_r   <= axis_position[cmd_idx];
          v_r   <= axis_velocity[cmd_idx];
          acc_r <= pos_bits[cmd.axis] ? 66'(cmd.force_req) : -66'(cmd.force_req);
        end
        caf_pkg::OP_MUL:   prod_r <= prod;
        caf_pkg::OP_SUB16: acc_r  <= acc_r - caf_pkg::rnd16(prod_r);
        caf_pkg::OP_SAT:   x_r    <= caf_pkg::sat32(acc_r);
        caf_pkg::OP_RND16: x_r    <= caf_pkg::sat32(caf_pkg::rnd16(prod_r));
        caf_pkg::OP_ADDV:  x_r    <= caf_pkg::sat32(66'(v_r) + caf_pkg::rnd32(prod_r));
        default: ;
      endcase
    end
  end

  // axis state, written back on the final step
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AXES; i++) begin
        axis_position[i] <= '0;
        axis_velocity[i] <= '0;
      end
    end else if (go && uc.op == caf_pkg::OP_ADDP) begin
      axis_position[ax_idx] <= new_pos;
      axis_velocity[ax_idx] <= x_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: holds one finished transaction so the next command can
  // start while this one waits downstream.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (go && uc.op == caf_pkg::OP_ADDP) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && uc.op == caf_pkg::OP_ADDP) begin
      res.axis_out <= ax_r;
      res.position <= new_pos;
      res.velocity <= x_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `CAF_ASSERT_NOW(a_step_range, clk, rst, 1'b1, step <= caf_pkg::STEP_LAST)
  `CAF_ASSERT_NOW(a_res_from_last, clk, rst, $rose(res_valid), $past(step) == caf_pkg::STEP_LAST)
  `CAF_ASSERT_NEXT(a_hold_last, clk, rst, (step == caf_pkg::STEP_LAST) && res_valid && res_stall, step == caf_pkg::STEP_LAST)

endmodule

// File: tb/sv/testbench.sv
module testbench;

  localparam int AXIS_COUNT = 6;
  // Padding beyond the time the block takes to answer a command.
  localparam int SETTLE_CYCLES = 24;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int SAMPLES_PER_PHASE = 170;
  localparam int PHASE_COUNT = 10;
  localparam int RUN_LIMIT_CYCLES = 1000000;

  // Moderate ranges for the randomised gains (Q16.16) and step (Q0.32).
  localparam logic [31:0] MODERATE_GAIN = 32'h0400_0000;
  localparam logic [31:0] MODERATE_IMASS = 32'h0010_0000;
  localparam logic [31:0] MODERATE_STEP = 32'h0400_0000;

  // One pending force sample; drain_first makes the driver hold it back
  // until every predicted result has come out.
  typedef struct {
    caf_pkg::cmd_t item;
    bit            drain_first;
  } force_sample_t;

  // Clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always #6 clk = ~clk;

  // DUT connections; every input starts at a known value
  logic          cmd_valid = 1'b0;
  logic          cmd_stall;
  caf_pkg::cmd_t cmd = '0;
  logic          res_valid;
  logic          res_stall = 1'b0;
  caf_pkg::res_t res;
  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [4:0]    paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;

  cartesian_admittance_filter_top #(
    .AXES(AXIS_COUNT)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd      (cmd),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res      (res),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Predictor state: register copies (index 0 = set A, 1 = set B) start at
  // their reset values, and the per-axis motion starts at rest.
  logic [31:0]        damping_gain [2] = '{32'd196608, 32'd32768000};
  logic [31:0]        stiffness_gain [2] = '{32'd0, 32'd6553600};
  logic [31:0]        inv_mass_gain = 32'd65536;
  logic [31:0]        step_size = 32'd4294967;
  logic [5:0]         force_sign_mask = 6'd40;
  logic [5:0]         group_b_sel = 6'd60;
  logic signed [31:0] axis_pos [AXIS_COUNT] = '{default: '0};
  logic signed [31:0] axis_vel [AXIS_COUNT] = '{default: '0};

  // Stimulus and scoreboard storage
  force_sample_t force_samples[$];
  caf_pkg::res_t predicted_motion[$];
  int unsigned   samples_queued = 0;
  int unsigned   samples_taken = 0;
  int unsigned   mismatch_count = 0;
  bit            cmd_fired = 1'b0;

  // Idle rates, set by the sequencer right after a rising edge
  int unsigned   send_idle_pct = 19;
  int unsigned   recv_idle_pct = 55;

  // Long receiver hold-offs: the sequencer bumps the request count, the
  // receiver process does the counting.
  int unsigned   hold_requests = 0;
  int unsigned   holds_started = 0;
  int unsigned   hold_left = 0;

  // Round to nearest, ties toward plus infinity: add half an LSB, then floor.
  function automatic logic signed [71:0] round_down_q(input logic signed [71:0] x,
                                                      input int sh);
    return (x + (72'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic logic signed [71:0] clamp_s32(input logic signed [71:0] x);
    if (x > 72'sd2147483647) return 72'sd2147483647;
    if (x < -72'sd2147483648) return -72'sd2147483648;
    return x;
  endfunction

  // One semi-implicit Euler update of the mass-spring-damper for the
  // addressed axis. Returns 0 for an axis beyond the axis count: no result,
  // no state change.
  function automatic bit admittance_step(input caf_pkg::cmd_t c, output caf_pkg::res_t r);
    logic [2:0]         ax;
    bit                 use_b;
    logic signed [71:0] frc, damp, stiff, imass, dt, p, v, net, acc, nv, np;
    ax = c.axis;
    if (ax >= AXIS_COUNT) return 1'b0;
    use_b = group_b_sel[ax];
    frc = $signed(c.force_req);
    damp = 72'(damping_gain[use_b]);
    stiff = 72'(stiffness_gain[use_b]);
    imass = 72'(inv_mass_gain);
    dt = 72'(step_size);
    p = $signed(axis_pos[ax]);
    v = $signed(axis_vel[ax]);
    // the most negative force negates exactly here, before the clamp
    net = (force_sign_mask[ax] ? frc : -frc)
          - round_down_q(damp * v, 16) - round_down_q(stiff * p, 16);
    net = clamp_s32(net);
    acc = clamp_s32(round_down_q(net * imass, 16));
    nv = clamp_s32(v + round_down_q(acc * dt, 32));
    // position integrates the new velocity
    np = clamp_s32(p + round_down_q(nv * dt, 32));
    axis_vel[ax] = nv[31:0];
    axis_pos[ax] = np[31:0];
    r.axis_out = ax;
    r.position = np[31:0];
    r.velocity = nv[31:0];
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  // APB write: setup cycle, access cycle, register taken at the edge with
  // pready high. The predictor copy follows once the write has landed.
  task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      caf_pkg::REG_DAMPING_A:   damping_gain[0] = value;
      caf_pkg::REG_DAMPING_B:   damping_gain[1] = value;
      caf_pkg::REG_STIFFNESS_A: stiffness_gain[0] = value;
      caf_pkg::REG_STIFFNESS_B: stiffness_gain[1] = value;
      caf_pkg::REG_INV_MASS:    inv_mass_gain = value;
      caf_pkg::REG_TIME_STEP:   step_size = value;
      caf_pkg::REG_POS_FORCE:   force_sign_mask = value[5:0];
      caf_pkg::REG_GROUP_B:     group_b_sel = value[5:0];
      default: ;
    endcase
  endtask

  function automatic logic [31:0] pick_setting(input logic [31:0] moderate_max);
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return $urandom;
      default: return $urandom_range(0, moderate_max);
    endcase
  endfunction

  // Register settings per phase: full scale first, then all zero, then random
  task automatic program_phase(input int phase);
    logic [31:0] da, db, sa, sb, im, ts, pf, gb;
    case (phase)
      1: begin
        // every gain and the step at full scale; group mask only has junk
        // in its unused upper bits, so all axes land on set A
        da = '1; db = '1; sa = '1; sb = '1; im = '1; ts = '1;
        pf = '1;
        gb = 32'hFFFF_FFC0;
      end
      2: begin
        // zero gains and zero step: the state must hold still
        da = '0; db = '0; sa = '0; sb = '0; im = '0; ts = '0;
        pf = '0;
        gb = 32'h0000_003F;
      end
      default: begin
        da = pick_setting(MODERATE_GAIN);
        db = pick_setting(MODERATE_GAIN);
        sa = pick_setting(MODERATE_GAIN);
        sb = pick_setting(MODERATE_GAIN);
        im = pick_setting(MODERATE_IMASS);
        ts = pick_setting(MODERATE_STEP);
        pf = $urandom;
        gb = $urandom;
      end
    endcase
    write_register(caf_pkg::REG_DAMPING_A, da);
    write_register(caf_pkg::REG_DAMPING_B, db);
    write_register(caf_pkg::REG_STIFFNESS_A, sa);
    write_register(caf_pkg::REG_STIFFNESS_B, sb);
    write_register(caf_pkg::REG_INV_MASS, im);
    write_register(caf_pkg::REG_TIME_STEP, ts);
    write_register(caf_pkg::REG_POS_FORCE, pf);
    write_register(caf_pkg::REG_GROUP_B, gb);
  endtask

  task automatic queue_sample(input logic [2:0] ax, input logic signed [31:0] frc,
                              input bit drain);
    force_sample_t s;
    s.item.axis = ax;
    s.item.force_req = frc;
    s.drain_first = drain;
    force_samples.insert(force_samples.size(), s);
    samples_queued++;
  endtask

  // Mostly in-range axes; a few beyond the axis count that must be dropped.
  // Forces mix full-range, small, and the extreme values.
  task automatic queue_random_samples(input int count);
    logic [2:0]         ax;
    logic signed [31:0] frc;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 6) ax = 3'($urandom_range(7, AXIS_COUNT));
      else ax = 3'($urandom_range(AXIS_COUNT - 1, 0));
      case ($urandom_range(9))
        0: frc = 32'sh7FFF_FFFF;
        1: frc = 32'sh8000_0000;
        2: frc = $urandom_range(1) ? 32'sh0 : -32'sd1;
        3, 4, 5, 6: frc = $urandom;
        default: frc = int'($urandom_range(0, 2097151)) - 1048576;
      endcase
      // one planned pause per phase, plus the odd random one
      queue_sample(ax, frc, (i == 60) || ($urandom_range(199) == 0));
    end
  endtask

  // Idle between phases: everything taken, every result back, then enough
  // cycles for a dropped command to clear the block.
  task automatic wait_for_drain();
    while (samples_taken != samples_queued || predicted_motion.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Command driver: a new transaction goes out only once the last one has
  // been taken, so a stalled payload never changes.
  always @(negedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (!cmd_valid || cmd_fired) begin
      if (force_samples.size() != 0 &&
          !(force_samples[0].drain_first && predicted_motion.size() != 0) &&
          $urandom_range(99) >= send_idle_pct) begin
        cmd <= force_samples[0].item;
        cmd_valid <= 1'b1;
        void'(force_samples.pop_front());
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, or a long counted hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else if (hold_left != 0) begin
      res_stall <= 1'b1;
      hold_left--;
    end else if (hold_requests != holds_started) begin
      holds_started = hold_requests;
      hold_left = LONG_HOLD_CYCLES - 1;
      res_stall <= 1'b1;
    end else begin
      res_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Monitor: predict on each taken command, check each taken result
  // against the oldest prediction, field by field.
  always @(posedge clk) begin
    caf_pkg::res_t want;
    caf_pkg::res_t got;
    cmd_fired = cmd_valid && !cmd_stall;
    if (!rst && cmd_fired) begin
      samples_taken++;
      if (admittance_step(cmd, want)) predicted_motion.insert(predicted_motion.size(), want);
    end
    if (!rst && res_valid && !res_stall) begin
      got = res;
      if (predicted_motion.size() == 0) begin
        report_mismatch($sformatf("unexpected result for axis %0d", got.axis_out));
      end else begin
        want = predicted_motion.pop_front();
        if (got.axis_out !== want.axis_out)
          report_mismatch($sformatf("axis_out %0d, predicted %0d",
                                    got.axis_out, want.axis_out));
        if (got.position !== want.position)
          report_mismatch($sformatf("axis %0d position %0d, predicted %0d",
                                    want.axis_out, got.position, want.position));
        if (got.velocity !== want.velocity)
          report_mismatch($sformatf("axis %0d velocity %0d, predicted %0d",
                                    want.axis_out, got.velocity, want.velocity));
      end
    end
  end

  // Sequencer
  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      // phase 0 runs on the reset values
      if (phase != 0) program_phase(phase);
      @(posedge clk);
      // sender quick and receiver busy, then the reverse, then flat out
      if (phase < 4) begin
        send_idle_pct = 19;
        recv_idle_pct = 55;
      end else if (phase < 7) begin
        send_idle_pct = 55;
        recv_idle_pct = 19;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // back up the block while commands keep coming
      if (phase == 2 || phase == 8) hold_requests++;

      if (phase == 0) begin
        // full-scale forces on every axis, both signs
        for (int a = 0; a < AXIS_COUNT; a++) queue_sample(3'(a), 32'sh7FFF_FFFF, 1'b0);
        for (int a = 0; a < AXIS_COUNT; a++) queue_sample(3'(a), 32'sh8000_0000, 1'b0);
        // axes past the end are swallowed without a result
        queue_sample(3'd6, 32'sd1, 1'b0);
        queue_sample(3'd7, -32'sd1, 1'b0);
        queue_sample(3'd0, 32'sd0, 1'b0);
        queue_sample(3'd3, -32'sd1, 1'b1);
        queue_sample(3'd5, 32'sd65536, 1'b0);
      end
      queue_random_samples(SAMPLES_PER_PHASE);
      wait_for_drain();
    end

    while (samples_taken != samples_queued) @(negedge clk);
    for (int n = 0; n < 5000 && predicted_motion.size() != 0; n++) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (predicted_motion.size() != 0)
      report_mismatch($sformatf("%0d predicted results never arrived",
                                predicted_motion.size()));
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    repeat (RUN_LIMIT_CYCLES) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
